// File: rtl/mfce_pkg.sv
// Shared types and constants for the clamped-edge median filter.
// No dependencies; imported by median_filter_clamped_edges_core.
`timescale 1ns / 1ps

package mfce_pkg;

	// Sample width is fixed by the data format (signed 1/16 degree steps).
	localparam int SAMPLE_W    = 12;
	// Default window length.
	localparam int WINDOW_DEF  = 5;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT,
		ST_ADV
	} mfce_state_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// File: rtl/median_filter_clamped_edges_core.sv
// Streaming 1-D median filter with clamped block edges.
// Depends on mfce_pkg for the sample type, default window and sequencer states.
`timescale 1ns / 1ps

// Median filter over a sliding window of WINDOW signed 12-bit samples
// (1/16 degree steps). Each result is the median of the window centred on one
// position of a block; positions outside the block repeat the first or last
// sample, so results lag the input by WINDOW/2 samples. An invalid sample is
// replaced by the last good sample of the block (zero before the first one).
// The transaction flagged block_end flushes the pending positions, and the
// last result of the block carries final_result. Sequence: a transaction in
// warm-up is taken without further work. A transaction that yields a result
// shifts the window as it is taken, then tries one median candidate at a time
// (at most WINDOW, a single compare row ranks one candidate against the whole
// window each cycle), then hands the result to the output register. At block
// end each further window position takes a shift step, a check step and, if
// it yields a result, the same scan and hand-off. The block holds item_stall
// high while it works on a transaction.
// The output register lets the next transaction enter while a result still
// waits on result_stall; the sequencer itself waits only when it needs the
// output register and it is still full.
module median_filter_clamped_edges_core
	import mfce_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic                sample_valid,
	input  logic                block_end,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic [SAMPLE_W-1:0] median_value,
	output logic                final_result
);

	localparam int HALF   = WINDOW / 2;
	localparam int FILL_W = $clog2(HALF + 1);
	localparam int CAND_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);

	localparam logic [FILL_W-1:0] HALF_F  = FILL_W'(HALF);
	localparam logic [CAND_W-1:0] LAST_C  = CAND_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0]  MID_CNT = CNT_W'(WINDOW / 2);

	mfce_state_t state_q, state_nx;

	sample_t           win_q [WINDOW];
	sample_t           last_good_q;
	sample_t           sample_q;     // sample that repeats during the flush
	sample_t           median_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] f_q;          // fill count seen by the flushing transaction
	logic [FILL_W-1:0] k_q;          // flush step
	logic              flush_q;
	logic [CAND_W-1:0] cand_q;

	logic              out_valid_q;
	sample_t           out_value_q;
	logic              out_final_q;

	logic              accept;
	sample_t           s_in;
	logic              out_free;
	logic              load_out;
	logic              emit_now;
	logic              is_hit;
	logic [CNT_W-1:0]  cnt_lt;
	logic [CNT_W-1:0]  cnt_le;
	sample_t           cand_val;

	assign accept   = item_valid && !item_stall;
	assign s_in     = sample_valid ? sample_t'(sample_value) : last_good_q;
	assign out_free = !out_valid_q || !result_stall;
	assign emit_now = (k_q >= (HALF_F - f_q));

	// Shared compare row: rank the current candidate against the whole window.
	assign cand_val = win_q[cand_q];
	always_comb begin
		cnt_lt = '0;
		cnt_le = '0;
		for (int j = 0; j < WINDOW; j++) begin
			cnt_lt = cnt_lt + CNT_W'(win_q[j] <  cand_val);
			cnt_le = cnt_le + CNT_W'(win_q[j] <= cand_val);
		end
		// Median: fewer than or exactly WINDOW/2 below it, more than WINDOW/2 at or below; the last candidate always hits.
		is_hit = ((cnt_lt <= MID_CNT) && (cnt_le > MID_CNT)) || (cand_q == LAST_C);
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (block_end)
						state_nx = ST_CHECK;
					else if (fill_q >= HALF_F)
						state_nx = ST_SCAN;
				end
			end
			ST_CHECK: state_nx = emit_now ? ST_SCAN : ST_ADV;
			ST_SCAN:  if (is_hit) state_nx = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					if (flush_q && (k_q != HALF_F))
						state_nx = ST_ADV;
					else
						state_nx = ST_IDLE;
				end
			end
			ST_ADV:   state_nx = ST_CHECK;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item_stall = 1'b1;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE:  item_stall = 1'b0;
			ST_EMIT:  load_out   = out_free;
			default:  ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			last_good_q <= '0;
			f_q         <= '0;
			k_q         <= '0;
			flush_q     <= 1'b0;
			cand_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				f_q     <= fill_q;
				k_q     <= '0;
				flush_q <= block_end;
				cand_q  <= '0;
				if (block_end) begin
					// Block done: drop fill and substitute for the next block.
					fill_q      <= '0;
					last_good_q <= '0;
				end else begin
					fill_q <= (fill_q >= HALF_F) ? HALF_F : fill_q + FILL_W'(1);
					if (sample_valid)
						last_good_q <= sample_t'(sample_value);
				end
			end
			if (state_q == ST_SCAN && !is_hit)
				cand_q <= cand_q + CAND_W'(1);
			if (state_q == ST_ADV) begin
				k_q    <= k_q + FILL_W'(1);
				cand_q <= '0;
			end
			if (state_q == ST_CHECK)
				cand_q <= '0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Window line and payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_in;
			if (fill_q == '0) begin
				// Block start: preload so the left edge repeats the first sample.
				for (int i = 0; i < WINDOW; i++)
					win_q[i] <= s_in;
			end else begin
				for (int i = 0; i < WINDOW - 1; i++)
					win_q[i] <= win_q[i+1];
				win_q[WINDOW-1] <= s_in;
			end
		end else if (state_q == ST_ADV) begin
			// Right edge: advance with the block's last sample.
			for (int i = 0; i < WINDOW - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[WINDOW-1] <= sample_q;
		end
		if (state_q == ST_SCAN && is_hit)
			median_q <= cand_val;
		if (load_out) begin
			out_value_q <= median_q;
			out_final_q <= flush_q && (k_q == HALF_F);
		end
	end

	assign result_valid = out_valid_q;
	assign median_value = out_value_q;
	assign final_result = out_final_q;

	// Assertions.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= HALF_F)
		else $error("fill count above half window");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> result_valid)
		else $error("result not presented after hand-off");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cand_q <= LAST_C))
		else $error("candidate index ran past window");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(result_valid) && final_result) |-> (fill_q == '0))
		else $error("final result while block fill still held");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_q && state_q != ST_IDLE) |-> (k_q <= HALF_F))
		else $error("flush step past half window");

endmodule
